// ----- rtl/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
package spq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_PEEK   = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]         command;
		logic signed [31:0] job_data;
		logic [7:0]         job_priority;
	} spq_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] head_data;
		logic [7:0]         head_priority;
		logic [4:0]         entry_count;
	} spq_rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic do_insert;
		logic do_remove;
		logic rpt_full;
		logic rpt_empty;
		logic rpt_head;
		logic emit;
	} spq_ctrl_t;

	// Datapath to controller.
	typedef struct packed {
		logic [1:0] command;
		logic       full;
		logic       empty;
	} spq_stat_t;

endpackage

// ----- rtl/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: sequencer plus slot datapath.
// Bounded priority queue of QUEUE_DEPTH entries kept sorted, head in slot
// zero; a smaller priority number is more urgent and equal priorities leave
// in arrival order. Issue a command by raising start while busy is low;
// that edge is the transfer of req. The command executes in the following
// cycle, where an insert compares every slot against the new priority at
// once, and the result appears on rsp for exactly one cycle with done high,
// the cycle after that. Busy is high only during the execute cycle, so a
// new command can transfer in the same cycle its predecessor's result is
// shown. The receiver cannot stall: capture rsp whenever done is high.
// Status reports full for an insert into a full queue and empty for remove
// or peek on an empty queue; neither changes the contents.
// head_data and head_priority are zero except on a successful remove or peek.
module sorted_priority_queue
	import spq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  spq_req_t req,
	output logic     done,
	output spq_rsp_t rsp
);

	spq_ctrl_t ctrl;
	spq_stat_t stat;

	// sequence commands: latch, execute, report
	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// hold the slots, shift on insert and remove, register the result
	spq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctrl   (ctrl),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

// ----- rtl/spq_ctrl.sv -----
// Command sequencer for the sorted priority queue.
module spq_ctrl
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  spq_stat_t stat,
	output spq_ctrl_t ctrl
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q == S_EXEC);

	always_comb begin
		ctrl = '0;
		case (state_q)
			S_IDLE: begin
				ctrl.load = start;
			end
			S_EXEC: begin
				ctrl.emit = 1'b1;
				if (stat.command == CMD_INSERT) begin
					ctrl.do_insert = !stat.full;
					ctrl.rpt_full  = stat.full;
				end else begin
					// command code three behaves as peek
					ctrl.rpt_empty = stat.empty;
					ctrl.rpt_head  = !stat.empty;
					ctrl.do_remove = !stat.empty && (stat.command == CMD_REMOVE);
				end
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.do_insert && ctrl.do_remove))
		else $error("insert and remove issued together");
	a_emit_returns: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |=> !busy)
		else $error("sequencer did not return to idle after a result");
	a_load_execs: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> ctrl.emit)
		else $error("accepted command was not executed");

endmodule

// ----- rtl/spq_dp.sv -----
// Slot registers, insert/remove shifter and result register of the queue.
module spq_dp
	import spq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  spq_req_t  req,
	input  spq_ctrl_t ctrl,
	output spq_stat_t stat,
	output logic      done,
	output spq_rsp_t  rsp
);

	spq_req_t           op_q;
	logic signed [31:0] slot_data_q [QUEUE_DEPTH];
	logic [7:0]         slot_prio_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_nxt;
	logic [QUEUE_DEPTH-1:0] keep;
	spq_rsp_t           rsp_q;
	logic               done_q;

	// operand latch
	always_ff @(posedge clk) begin
		if (ctrl.load) op_q <= req;
	end

	assign stat.command = op_q.command;
	assign stat.full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty   = (count_q == '0);

	// a slot stays put on insert when it is valid and not less urgent than the new job;
	// the stored order makes this a prefix
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			keep[i] = (CNT_W'(i) < count_q) && (slot_prio_q[i] <= op_q.job_priority);
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (ctrl.do_insert) count_nxt = count_q + 1'b1;
		else if (ctrl.do_remove) count_nxt = count_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (ctrl.do_insert && !keep[i]) begin
				if (i == 0 || keep[(i == 0) ? 0 : i - 1]) begin
					slot_data_q[i] <= op_q.job_data;
					slot_prio_q[i] <= op_q.job_priority;
				end else begin
					slot_data_q[i] <= slot_data_q[(i == 0) ? 0 : i - 1];
					slot_prio_q[i] <= slot_prio_q[(i == 0) ? 0 : i - 1];
				end
			end else if (ctrl.do_remove && i < QUEUE_DEPTH - 1) begin
				slot_data_q[i] <= slot_data_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
				slot_prio_q[i] <= slot_prio_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= ctrl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			rsp_q.status        <= ctrl.rpt_full ? STAT_FULL :
			                       (ctrl.rpt_empty ? STAT_EMPTY : STAT_OK);
			rsp_q.head_data     <= ctrl.rpt_head ? slot_data_q[0] : 32'sd0;
			rsp_q.head_priority <= ctrl.rpt_head ? slot_prio_q[0] : 8'd0;
			rsp_q.entry_count   <= 5'(count_nxt);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count beyond depth");
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.do_insert |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not add one entry");
	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (slot_prio_q[0] <= slot_prio_q[1]))
		else $error("head slots out of order");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the sorted priority queue: directed and random commands.
module tb
	import spq_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// The fourth command code is decoded by the block as a peek.
	localparam logic [1:0] CMD_PEEK_ALT = 2'd3;
	localparam int         QUIET_LIMIT  = 400;
	localparam int         TAIL_CYCLES  = 8;

	typedef struct {
		spq_req_t req;
		bit       drain;
	} pend_item_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	spq_req_t req = '0;
	logic     done;
	spq_rsp_t rsp;

	sorted_priority_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #1 clk = ~clk;

	// Commands waiting to be issued; the head is what the driver presents.
	pend_item_t pend_q[$];
	// Responses predicted for transferred commands, oldest first.
	spq_rsp_t   rsp_expected_q[$];

	// Transfer and response counts are updated with nonblocking assignments so
	// that every block sees the values from before the current edge.
	int unsigned n_sent = 0;
	int unsigned n_rcv = 0;
	bit          stim_done = 1'b0;
	int unsigned n_errors = 0;

	// Coverage tallies kept by the shadow queue.
	int unsigned n_insert = 0, n_full = 0, n_remove = 0, n_peek = 0, n_empty = 0;
	int unsigned max_fill = 0;

	// Shadow copy of the queue contents, head in entry zero.
	logic signed [31:0] shadow_data[QUEUE_DEPTH];
	logic [7:0]         shadow_prio[QUEUE_DEPTH];
	int unsigned        shadow_cnt = 0;

	// Apply one command to the shadow queue and return the response it yields.
	function automatic spq_rsp_t queue_step(spq_req_t r);
		spq_rsp_t    o;
		int unsigned pos;
		o = '0;
		o.status = STAT_OK;
		if (r.command == CMD_INSERT) begin
			n_insert++;
			if (shadow_cnt >= QUEUE_DEPTH) begin
				o.status = STAT_FULL;
				n_full++;
			end else begin
				// Go behind every entry of equal or more urgent priority.
				pos = 0;
				while (pos < shadow_cnt && shadow_prio[pos] <= r.job_priority)
					pos++;
				for (int unsigned i = shadow_cnt; i > pos; i--) begin
					shadow_data[i] = shadow_data[i - 1];
					shadow_prio[i] = shadow_prio[i - 1];
				end
				shadow_data[pos] = r.job_data;
				shadow_prio[pos] = r.job_priority;
				shadow_cnt++;
			end
		end else begin
			if (r.command == CMD_REMOVE)
				n_remove++;
			else
				n_peek++;
			if (shadow_cnt == 0) begin
				o.status = STAT_EMPTY;
				n_empty++;
			end else begin
				o.head_data     = shadow_data[0];
				o.head_priority = shadow_prio[0];
				// Remove shifts the queue up; peek and the alternate code leave it.
				if (r.command == CMD_REMOVE) begin
					for (int unsigned i = 1; i < shadow_cnt; i++) begin
						shadow_data[i - 1] = shadow_data[i];
						shadow_prio[i - 1] = shadow_prio[i];
					end
					shadow_cnt--;
				end
			end
		end
		if (shadow_cnt > max_fill)
			max_fill = shadow_cnt;
		o.entry_count = shadow_cnt[4:0];
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] response %0d: %s mismatch, got 0x%0h expected 0x%0h",
			$realtime, n_rcv, what, got, want);
		n_errors++;
	endtask

	task automatic add_cmd(input logic [1:0] cmd, input logic [31:0] data,
			input logic [7:0] prio, input bit drain);
		pend_item_t p;
		p.req.command      = cmd;
		p.req.job_data     = data;
		p.req.job_priority = prio;
		p.drain            = drain;
		pend_q.push_back(p);
	endtask

	// Driver: detect the transfer, predict its response, then present the next
	// command unless inside a gap or holding for the queue to drain.
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;

	always @(posedge clk) begin
		bit xfer;
		bit go;
		xfer = 1'b0;
		go   = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				xfer = 1'b1;
				rsp_expected_q.push_back(queue_step(req));
				n_sent <= n_sent + 1;
				void'(pend_q.pop_front());
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					// About a third of the bursts run back to back.
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end
			end
			if (pend_q.size() != 0) begin
				if (pend_q[0].drain) begin
					// Hold until every response up to the last edge has come in.
					if (!xfer && !start && n_sent == n_rcv)
						pend_q[0].drain = 1'b0;
				end else if (gap_left > 0) begin
					gap_left--;
				end else begin
					go = 1'b1;
				end
			end
		end
		start <= go;
		if (go)
			req <= pend_q[0].req;
		stim_done <= arst_n && pend_q.size() == 0;
	end

	// Monitor: every done cycle carries one response, checked against the
	// oldest prediction still waiting.
	always @(posedge clk) begin
		spq_rsp_t want;
		if (arst_n && done) begin
			if (n_sent == n_rcv) begin
				$display("[%0t] unexpected response, status %0d count %0d", $realtime,
					rsp.status, rsp.entry_count);
				n_errors++;
			end else begin
				want = rsp_expected_q.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", 32'(rsp.status), 32'(want.status));
				if (rsp.head_data !== want.head_data)
					report_mismatch("head_data", rsp.head_data, want.head_data);
				if (rsp.head_priority !== want.head_priority)
					report_mismatch("head_priority", 32'(rsp.head_priority),
						32'(want.head_priority));
				if (rsp.entry_count !== want.entry_count)
					report_mismatch("entry_count", 32'(rsp.entry_count),
						32'(want.entry_count));
				n_rcv <= n_rcv + 1;
			end
		end
	end

	// Watchdog: end the run if neither a transfer nor a response shows up for
	// too long.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned n_rand;
		int unsigned phase_left;
		bit          filling;
		logic [1:0]  cmd;
		logic [7:0]  prio;

		// Directed: empty-queue corner cases first.
		add_cmd(CMD_PEEK, 32'h1234_5678, 8'hFF, 1'b0);
		add_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 8'h00, 1'b0);
		add_cmd(CMD_PEEK_ALT, 32'h8000_0000, 8'hAA, 1'b0);
		// Field extremes and a tie on the most urgent priority.
		add_cmd(CMD_INSERT, 32'h8000_0000, 8'hFF, 1'b0);
		add_cmd(CMD_INSERT, 32'h7FFF_FFFF, 8'h00, 1'b0);
		add_cmd(CMD_INSERT, 32'h0000_0000, 8'h00, 1'b0);
		add_cmd(CMD_INSERT, 32'hFFFF_FFFF, 8'h80, 1'b0);
		add_cmd(CMD_INSERT, 32'h5555_5555, 8'hFF, 1'b0);
		add_cmd(CMD_PEEK, 32'h0, 8'h0, 1'b0);
		add_cmd(CMD_PEEK_ALT, 32'hFFFF_FFFF, 8'hFF, 1'b0);
		// Drain: the older of the tied entries must leave first.
		repeat (5)
			add_cmd(CMD_REMOVE, 32'hAAAA_AAAA, 8'h55, 1'b0);
		add_cmd(CMD_REMOVE, 32'h0, 8'h0, 1'b0);
		add_cmd(CMD_PEEK_ALT, 32'h0, 8'h0, 1'b0);

		// Random: alternate fill and drain phases so the queue swings between
		// empty and full; ties are frequent with the narrow priority range.
		n_rand     = 0;
		phase_left = 0;
		filling    = 1'b0;
		while (n_rand < 450) begin
			if (phase_left == 0) begin
				filling    = !filling;
				phase_left = $urandom_range(20, 50);
			end
			phase_left--;
			case ($urandom_range(0, 9))
				0: cmd = ($urandom_range(0, 1) != 0) ? CMD_PEEK : CMD_PEEK_ALT;
				1, 2: cmd = filling ? CMD_REMOVE : CMD_INSERT;
				default: cmd = filling ? CMD_INSERT : CMD_REMOVE;
			endcase
			prio = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 3));
			// Pause for a full drain at the start and now and then after.
			add_cmd(cmd, $urandom, prio, n_rand % 120 == 0);
			n_rand++;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every command to transfer and every response to arrive.
		do
			@(posedge clk);
		while (!stim_done || n_sent != n_rcv);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_sent != n_rcv) begin
			$display("%0d responses never arrived", n_sent - n_rcv);
			n_errors++;
		end

		$display("Ran %0d commands: %0d inserts (%0d while full), %0d removes, %0d peeks",
			n_sent, n_insert, n_full, n_remove, n_peek);
		$display("%0d commands found the queue empty; peak fill %0d of %0d",
			n_empty, max_fill, QUEUE_DEPTH);
		if (n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_dp.sv
rtl/sorted_priority_queue.sv
dv/tb.sv
